>>> sv/imusfd_pkg.sv
// shared types and constants of the imu serial frame decoder
package imusfd_pkg;

    // frame framing bytes
    localparam logic [7:0] SYNC_BYTE = 8'h55;
    localparam logic [7:0] HDR_GYRO  = 8'h52;
    localparam logic [7:0] HDR_ANGLE = 8'h53;

    // byte positions inside a frame
    localparam int unsigned COUNT_W = 4;
    localparam logic [COUNT_W-1:0] COUNT_HUNT  = 4'd0;
    localparam logic [COUNT_W-1:0] COUNT_FIRST = 4'd2;
    localparam logic [COUNT_W-1:0] WORD_FIRST  = 4'd4;
    localparam logic [COUNT_W-1:0] WORD_LAST   = 4'd7;
    localparam logic [COUNT_W-1:0] CHECK_INDEX = 4'd10;

    // frame kind codes
    localparam logic KIND_GYRO  = 1'b0;
    localparam logic KIND_ANGLE = 1'b1;

    // result field widths
    localparam int unsigned RATE_W    = 25;
    localparam int unsigned HEADING_W = 22;
    localparam int unsigned RAW_W     = 16;

    // scale factors to 1/8192 degree units
    localparam logic signed [9:0] RATE_SCALE = 10'sd500;
    localparam logic signed [6:0] YAW_SCALE  = 7'sd45;

    // checked frame handed from the parser to the result stage
    typedef struct packed {
        logic              kind;
        logic [RAW_W-1:0]  word_hi;   // bytes 6-7
        logic [RAW_W-1:0]  word_lo;   // bytes 4-5
    } frame_t;

endpackage

>>> sv/imusfd_parser.sv
// byte hunter, checksum and word capture for 11-byte sensor frames
module imusfd_parser (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 byte_valid,
    input  logic [7:0]           byte_data,
    input  logic                 frame_move,
    output logic                 frame_valid,
    output imusfd_pkg::frame_t   frame
);
    import imusfd_pkg::*;

    logic [7:0]         prior_byte_reg, prior_byte_next;
    logic [COUNT_W-1:0] byte_count_reg, byte_count_next;
    logic               kind_held_reg, kind_held_next;
    logic [7:0]         running_sum_reg, running_sum_next;
    logic [31:0]        captured_reg, captured_next;
    logic               frame_valid_reg, frame_valid_next;
    frame_t             frame_reg, frame_next;

    // frame state machine on each accepted byte
    always_comb begin
        prior_byte_next  = prior_byte_reg;
        byte_count_next  = byte_count_reg;
        kind_held_next   = kind_held_reg;
        running_sum_next = running_sum_reg;
        captured_next    = captured_reg;
        frame_valid_next = frame_valid_reg && !frame_move;
        frame_next       = frame_reg;
        if (byte_valid) begin
            if (byte_count_reg == COUNT_HUNT) begin
                prior_byte_next = byte_data;
                if (prior_byte_reg == SYNC_BYTE &&
                    (byte_data == HDR_GYRO || byte_data == HDR_ANGLE)) begin
                    byte_count_next  = COUNT_FIRST;
                    kind_held_next   = (byte_data == HDR_ANGLE) ? KIND_ANGLE : KIND_GYRO;
                    running_sum_next = SYNC_BYTE + byte_data;
                    captured_next    = '0;
                end
            end else if (byte_count_reg < CHECK_INDEX) begin
                if (byte_count_reg >= WORD_FIRST && byte_count_reg <= WORD_LAST) begin
                    captured_next[{byte_count_reg[1:0], 3'b000} +: 8] = byte_data;
                end
                running_sum_next = running_sum_reg + byte_data;
                byte_count_next  = byte_count_reg + 1'b1;
            end else begin
                // checksum byte ends the frame either way
                byte_count_next = COUNT_HUNT;
                if (running_sum_reg == byte_data) begin
                    frame_valid_next   = 1'b1;
                    frame_next.kind    = kind_held_reg;
                    frame_next.word_lo = captured_reg[RAW_W-1:0];
                    frame_next.word_hi = captured_reg[2*RAW_W-1:RAW_W];
                end
            end
        end
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prior_byte_reg  <= '0;
            byte_count_reg  <= COUNT_HUNT;
            kind_held_reg   <= KIND_GYRO;
            running_sum_reg <= '0;
            captured_reg    <= '0;
            frame_valid_reg <= 1'b0;
        end else begin
            prior_byte_reg  <= prior_byte_next;
            byte_count_reg  <= byte_count_next;
            kind_held_reg   <= kind_held_next;
            running_sum_reg <= running_sum_next;
            captured_reg    <= captured_next;
            frame_valid_reg <= frame_valid_next;
        end
    end

    // checked frame payload
    always_ff @(posedge aclk) begin
        frame_reg <= frame_next;
    end

    assign frame_valid = frame_valid_reg;
    assign frame       = frame_reg;

endmodule

>>> sv/imu_serial_frame_decoder_unit.sv
// top level of the imu serial frame decoder: parser, scaling and result register
// A checked frame is registered in the parser, then in the result register once that is free.
// Throughput: one byte per cycle unless stalled; a good frame needs at least 11 bytes.
// The input stalls only while a checked frame waits behind an untaken result.
// Reset (aresetn low, synchronous) returns to hunting and clears stored values except the frame payload.
module imu_serial_frame_decoder_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [24:0] rate_y, [49:25] rate_z, [71:50] heading
    output logic [0:0]  m_tuser    // [0] frame_kind
);
    import imusfd_pkg::*;

    logic   frame_valid;
    frame_t frame;
    logic   frame_move;
    logic   byte_accept;

    logic                        m_valid_reg, m_valid_next;
    logic                        kind_reg;
    logic signed [RATE_W-1:0]    rate_y_reg, rate_y_next;
    logic signed [RATE_W-1:0]    rate_z_reg, rate_z_next;
    logic signed [HEADING_W-1:0] heading_reg, heading_next;
    logic signed [RATE_W-1:0]    rate_y_full, rate_z_full;
    logic signed [HEADING_W-1:0] heading_full;

    // handshakes
    assign frame_move  = frame_valid && (!m_valid_reg || m_tready);
    assign s_tready    = !frame_valid || frame_move;
    assign byte_accept = s_tvalid && s_tready;

    imusfd_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .byte_valid  (byte_accept),
        .byte_data   (s_tdata),
        .frame_move  (frame_move),
        .frame_valid (frame_valid),
        .frame       (frame)
    );

    // scale raw words to 1/8192 degree units
    assign rate_y_full  = RATE_W'($signed(frame.word_lo)) * RATE_W'(RATE_SCALE);
    assign rate_z_full  = RATE_W'($signed(frame.word_hi)) * RATE_W'(RATE_SCALE);
    assign heading_full = HEADING_W'($signed(frame.word_hi)) * HEADING_W'(YAW_SCALE);

    // update held values for the frame kind
    always_comb begin
        rate_y_next  = rate_y_reg;
        rate_z_next  = rate_z_reg;
        heading_next = heading_reg;
        m_valid_next = m_valid_reg && !m_tready;
        if (frame_move) begin
            m_valid_next = 1'b1;
            if (frame.kind == KIND_GYRO) begin
                rate_y_next = rate_y_full;
                rate_z_next = rate_z_full;
            end else begin
                heading_next = heading_full;
            end
        end
    end

    // result register and held values
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            kind_reg    <= KIND_GYRO;
            rate_y_reg  <= '0;
            rate_z_reg  <= '0;
            heading_reg <= '0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (frame_move) begin
                kind_reg <= frame.kind;
            end
            rate_y_reg  <= rate_y_next;
            rate_z_reg  <= rate_z_next;
            heading_reg <= heading_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {heading_reg, rate_z_reg, rate_y_reg};
    assign m_tuser  = kind_reg;

endmodule
